[hw/rtl/cvkf_pkg.sv]
// ----------------------------------------------------------------------------
// cvkf_pkg
// Shared types, constants and the micro-program of the 1-D Kalman filter.
// ----------------------------------------------------------------------------
package cvkf_pkg;

   localparam int FRAC_BITS_DEF = 16;
   localparam int WORD_BITS_DEF = 32;

   localparam int TIME_STEP_W   = 20;
   localparam int MEAS_W        = 32;
   localparam int EST_W         = 32;
   localparam int NOISE_W       = 23;
   localparam int CSR_DATA_W    = 31;
   localparam int CSR_INDEX_W   = 3;
   localparam int REQ_DATA_W    = 56;
   localparam int RSP_DATA_W    = 64;

   // state values loaded at reset (reset values of the variance registers)
   localparam logic [NOISE_W-1:0] PROCESS_NOISE_RST     = 23'd176947;
   localparam logic [NOISE_W-1:0] MEASUREMENT_NOISE_RST = 23'd786;
   localparam int                 INIT_PXX              = 6553600;
   localparam int                 INIT_PVV              = 655360;

   // pi with 32 fraction bits
   localparam logic [63:0] PI_Q32 = 64'd13493037705;

   localparam int PC_W      = 5;
   localparam logic [PC_W-1:0] PC_LAST = 5'd29;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_PROCESS_NOISE     = 3'd0,
      CSR_MEASUREMENT_NOISE = 3'd1,
      CSR_PERIODIC_MODE     = 3'd2,
      CSR_INIT_POS_VAR      = 3'd3,
      CSR_INIT_VEL_VAR      = 3'd4
   } csr_index_type;

   typedef enum logic [2:0] {
      OP_ADD,
      OP_SUB,
      OP_MUL,
      OP_DIV,
      OP_WRAP
   } op_type;

   typedef enum logic [4:0] {
      R_X, R_V, R_PXX, R_PXV, R_PVV,
      R_DT, R_DT2, R_Z, R_Q, R_R,
      R_T0, R_T1, R_T2, R_XP, R_PXXP, R_PXVP, R_PVVP, R_Y, R_S
   } reg_type;

   typedef struct packed {
      op_type  op;
      reg_type a;
      reg_type b;
      reg_type d;
   } uop_type;

   typedef struct packed {
      logic    load;
      logic    start;
      logic    emit;
      uop_type uop;
   } dp_cmd_type;

   typedef struct packed {
      logic done;
      logic out_free;
   } dp_stat_type;

   typedef struct packed {
      logic [NOISE_W-1:0] process_noise;
      logic [NOISE_W-1:0] measurement_noise;
      logic               periodic_mode;
   } cfg_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ISSUE,
      ST_WAIT,
      ST_EMIT
   } fsm_type;

   function automatic logic [63:0] pi_q(input int frac);
      logic [63:0] half;
      half = 64'd1 << (31 - frac);
      return (PI_Q32 + half) >> (32 - frac);
   endfunction

   function automatic uop_type mk(input op_type op, input reg_type a,
                                  input reg_type b, input reg_type d);
      uop_type u;
      u.op = op;
      u.a  = a;
      u.b  = b;
      u.d  = d;
      return u;
   endfunction

   function automatic uop_type prog_step(input logic [PC_W-1:0] pc);
      uop_type u;
      case (pc)
         5'd0:    u = mk(OP_MUL,  R_Q,    R_DT,   R_T0);
         5'd1:    u = mk(OP_MUL,  R_T0,   R_DT,   R_T0);
         5'd2:    u = mk(OP_MUL,  R_DT,   R_V,    R_T1);
         5'd3:    u = mk(OP_ADD,  R_X,    R_T1,   R_XP);
         5'd4:    u = mk(OP_MUL,  R_DT,   R_DT,   R_T1);
         5'd5:    u = mk(OP_MUL,  R_T1,   R_PVV,  R_T1);
         5'd6:    u = mk(OP_MUL,  R_DT2,  R_PXV,  R_T2);
         5'd7:    u = mk(OP_ADD,  R_T1,   R_T2,   R_PXXP);
         5'd8:    u = mk(OP_ADD,  R_PXXP, R_PXX,  R_PXXP);
         5'd9:    u = mk(OP_MUL,  R_DT,   R_PVV,  R_T1);
         5'd10:   u = mk(OP_ADD,  R_T1,   R_PXV,  R_PXVP);
         5'd11:   u = mk(OP_ADD,  R_PVV,  R_T0,   R_PVVP);
         5'd12:   u = mk(OP_SUB,  R_Z,    R_XP,   R_Y);
         5'd13:   u = mk(OP_WRAP, R_Y,    R_Y,    R_Y);
         5'd14:   u = mk(OP_ADD,  R_PXXP, R_R,    R_S);
         5'd15:   u = mk(OP_MUL,  R_PXXP, R_Y,    R_T1);
         5'd16:   u = mk(OP_DIV,  R_T1,   R_S,    R_T1);
         5'd17:   u = mk(OP_ADD,  R_XP,   R_T1,   R_X);
         5'd18:   u = mk(OP_MUL,  R_PXVP, R_Y,    R_T1);
         5'd19:   u = mk(OP_DIV,  R_T1,   R_S,    R_T1);
         5'd20:   u = mk(OP_ADD,  R_V,    R_T1,   R_V);
         5'd21:   u = mk(OP_MUL,  R_PXXP, R_PXXP, R_T1);
         5'd22:   u = mk(OP_DIV,  R_T1,   R_S,    R_T1);
         5'd23:   u = mk(OP_SUB,  R_PXXP, R_T1,   R_PXX);
         5'd24:   u = mk(OP_MUL,  R_PXVP, R_PXXP, R_T1);
         5'd25:   u = mk(OP_DIV,  R_T1,   R_S,    R_T1);
         5'd26:   u = mk(OP_SUB,  R_PXVP, R_T1,   R_PXV);
         5'd27:   u = mk(OP_MUL,  R_PXVP, R_PXVP, R_T1);
         5'd28:   u = mk(OP_DIV,  R_T1,   R_S,    R_T1);
         5'd29:   u = mk(OP_SUB,  R_PVVP, R_T1,   R_PVV);
         default: u = mk(OP_ADD,  R_T2,   R_T2,   R_T2);
      endcase
      return u;
   endfunction

endpackage

[hw/rtl/cvkf_ctrl.sv]
// ----------------------------------------------------------------------------
// cvkf_ctrl
// Sequencer: steps through the micro-program, one operation at a time.
// ----------------------------------------------------------------------------
module cvkf_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   output cvkf_pkg::dp_cmd_type cmd,
   input  cvkf_pkg::dp_stat_type stat
);
   import cvkf_pkg::*;

   fsm_type          state_ff, state_in;
   logic [PC_W-1:0]  pc_ff, pc_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         pc_ff    <= '0;
      end else begin
         state_ff <= state_in;
         pc_ff    <= pc_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      pc_in      = pc_ff;
      req_tready = 1'b0;
      cmd.load   = 1'b0;
      cmd.start  = 1'b0;
      cmd.emit   = 1'b0;
      cmd.uop    = prog_step(pc_ff);
      case (state_ff)
         ST_IDLE: begin
            req_tready = !reset;
            if (req_tvalid && !reset) begin
               cmd.load = 1'b1;
               pc_in    = '0;
               state_in = ST_ISSUE;
            end
         end
         ST_ISSUE: begin
            cmd.start = 1'b1;
            state_in  = ST_WAIT;
         end
         ST_WAIT: begin
            if (stat.done) begin
               if (pc_ff == PC_LAST) begin
                  state_in = ST_EMIT;
               end else begin
                  pc_in    = pc_ff + 1'b1;
                  state_in = ST_ISSUE;
               end
            end
         end
         ST_EMIT: begin
            if (stat.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

`ifndef NO_ASSERTIONS
   a_accept_issues: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (state_ff == ST_ISSUE))
      else $error("accepted item did not start the program");
   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> stat.out_free)
      else $error("result emitted into a full output register");
   a_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      stat.done |-> (state_ff == ST_WAIT))
      else $error("operation finished outside wait state");
`endif

endmodule

[hw/rtl/cvkf_dp.sv]
// ----------------------------------------------------------------------------
// cvkf_dp
// Datapath: filter state, temporaries, a shared two-pass multiplier, a
// radix-2 restoring divider, saturating add/subtract, periodic wrap and the output register.
// ----------------------------------------------------------------------------
module cvkf_dp #(
   parameter int FRAC_BITS = cvkf_pkg::FRAC_BITS_DEF,
   parameter int WORD_BITS = cvkf_pkg::WORD_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  cvkf_pkg::dp_cmd_type                cmd,
   output cvkf_pkg::dp_stat_type               stat,
   input  cvkf_pkg::cfg_type                   cfg,
   input  logic [cvkf_pkg::TIME_STEP_W-1:0]    time_step,
   input  logic signed [cvkf_pkg::MEAS_W-1:0]  measurement,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic signed [cvkf_pkg::EST_W-1:0]   position_estimate,
   output logic signed [cvkf_pkg::EST_W-1:0]   velocity_estimate
);
   import cvkf_pkg::*;

   localparam int W    = WORD_BITS;
   localparam int F    = FRAC_BITS;
   localparam int HL   = W / 2;
   localparam int HB   = W - HL;
   localparam int N    = W + F;
   localparam int CW   = 2 * W;
   localparam int CNTW = $clog2(N + 1);
   localparam logic [CNTW-1:0] MUL_LAST = CNTW'(3);
   localparam logic [CNTW-1:0] DIV_LAST = CNTW'(N);
   localparam logic [CW-1:0] MAG_LIM = CW'(1) << (W - 1);
   localparam logic [CW-1:0] MAG_MAX = MAG_LIM - CW'(1);
   localparam logic signed [63:0] WMAX64 = (64'sd1 <<< (W - 1)) - 64'sd1;
   localparam logic signed [63:0] WMIN64 = -WMAX64 - 64'sd1;
   localparam logic signed [63:0] PI64   = signed'(pi_q(F));
   localparam logic signed [63:0] TWO_PI64 = PI64 + PI64;

   function automatic logic signed [W-1:0] sat64(input logic signed [63:0] v);
      logic signed [W-1:0] r;
      if (v > WMAX64) r = W'(WMAX64);
      else if (v < WMIN64) r = W'(WMIN64);
      else r = v[W-1:0];
      return r;
   endfunction

   function automatic logic signed [W-1:0] sat_mag(input logic [CW-1:0] m,
                                                   input logic neg);
      logic [CW-1:0]       t;
      logic signed [W-1:0] r;
      t = ~m + CW'(1);
      if (neg) r = (m > MAG_LIM) ? W'(WMIN64) : t[W-1:0];
      else     r = (m > MAG_MAX) ? W'(WMAX64) : m[W-1:0];
      return r;
   endfunction

   function automatic logic [W-1:0] mag(input logic signed [W-1:0] v);
      return v[W-1] ? (~v + W'(1)) : v;
   endfunction

   logic signed [W-1:0] x_ff, v_ff, pxx_ff, pxv_ff, pvv_ff;
   logic signed [W-1:0] t0_ff, t1_ff, t2_ff, xp_ff, pxxp_ff, pxvp_ff, pvvp_ff;
   logic signed [W-1:0] y_ff, s_ff, dt_ff, dt2_ff, z_ff;
   logic signed [W-1:0] q_w, r_w;

   op_type              op_ff;
   reg_type             d_ff;
   logic signed [W-1:0] a_ff, b_ff;
   logic [W-1:0]        ma_ff, mb_ff;
   logic                neg_ff, bz_ff, busy_ff;
   logic [CNTW-1:0]     cnt_ff;
   logic [W+HB-1:0]     prod_ff;
   logic [CW-1:0]       acc_ff;
   logic [W-1:0]        rem_ff, dvd_ff;
   logic [N-1:0]        quo_ff;

   logic signed [W-1:0] opa_in, opb_in, res_in;
   logic [HB-1:0]       mb_part;
   logic [W:0]          r2, diff;
   logic                ge, done;
   logic signed [63:0]  sum64, y64;
   logic signed [EST_W-1:0] pos_ff, vel_ff;
   logic                rsp_valid_ff;
   logic signed [63:0]  x64, v64;

   assign q_w = W'(cfg.process_noise);
   assign r_w = W'(cfg.measurement_noise);

   function automatic logic signed [W-1:0] pick(input reg_type s,
      input logic signed [W-1:0] x, v, pxx, pxv, pvv, t0, t1, t2, xp, pxxp,
      input logic signed [W-1:0] pxvp, pvvp, y, sv, dt, dt2, z, q, r);
      logic signed [W-1:0] o;
      case (s)
         R_X:     o = x;
         R_V:     o = v;
         R_PXX:   o = pxx;
         R_PXV:   o = pxv;
         R_PVV:   o = pvv;
         R_DT:    o = dt;
         R_DT2:   o = dt2;
         R_Z:     o = z;
         R_Q:     o = q;
         R_R:     o = r;
         R_T0:    o = t0;
         R_T1:    o = t1;
         R_T2:    o = t2;
         R_XP:    o = xp;
         R_PXXP:  o = pxxp;
         R_PXVP:  o = pxvp;
         R_PVVP:  o = pvvp;
         R_Y:     o = y;
         R_S:     o = sv;
         default: o = '0;
      endcase
      return o;
   endfunction

   always_comb begin
      opa_in = pick(cmd.uop.a, x_ff, v_ff, pxx_ff, pxv_ff, pvv_ff, t0_ff, t1_ff,
                    t2_ff, xp_ff, pxxp_ff, pxvp_ff, pvvp_ff, y_ff, s_ff, dt_ff,
                    dt2_ff, z_ff, q_w, r_w);
      opb_in = pick(cmd.uop.b, x_ff, v_ff, pxx_ff, pxv_ff, pvv_ff, t0_ff, t1_ff,
                    t2_ff, xp_ff, pxxp_ff, pxvp_ff, pvvp_ff, y_ff, s_ff, dt_ff,
                    dt2_ff, z_ff, q_w, r_w);
   end

   // shared multiplier: low half of the second operand, then the high half
   assign mb_part = (cnt_ff == '0) ? HB'(mb_ff[HL-1:0]) : mb_ff[W-1:HL];

   // divider step
   assign r2   = {rem_ff, dvd_ff[W-1]};
   assign ge   = (r2 >= {1'b0, mb_ff});
   assign diff = r2 - {1'b0, mb_ff};

   always_comb begin
      sum64 = '0;
      y64   = 64'(a_ff);
      res_in = a_ff;
      done  = 1'b0;
      case (op_ff)
         OP_ADD: begin
            sum64  = 64'(a_ff) + 64'(b_ff);
            res_in = sat64(sum64);
            done   = busy_ff;
         end
         OP_SUB: begin
            sum64  = 64'(a_ff) - 64'(b_ff);
            res_in = sat64(sum64);
            done   = busy_ff;
         end
         OP_WRAP: begin
            if (cfg.periodic_mode && (y64 > PI64)) begin
               sum64 = y64 - TWO_PI64;
            end else if (cfg.periodic_mode && (y64 < -PI64)) begin
               sum64 = y64 + TWO_PI64;
            end else begin
               sum64 = y64;
            end
            res_in = sat64(sum64);
            done   = busy_ff;
         end
         OP_MUL: begin
            res_in = sat_mag(acc_ff >> F, neg_ff);
            done   = busy_ff && (cnt_ff == MUL_LAST);
         end
         OP_DIV: begin
            res_in = bz_ff ? '0 : sat_mag(CW'(quo_ff), neg_ff);
            done   = busy_ff && (cnt_ff == DIV_LAST);
         end
         default: begin
            res_in = a_ff;
            done   = busy_ff;
         end
      endcase
   end

   // operation unit
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (cmd.start) begin
         busy_ff <= 1'b1;
         cnt_ff  <= '0;
      end else if (done) begin
         busy_ff <= 1'b0;
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         op_ff  <= cmd.uop.op;
         d_ff   <= cmd.uop.d;
         a_ff   <= opa_in;
         b_ff   <= opb_in;
         ma_ff  <= mag(opa_in);
         mb_ff  <= mag(opb_in);
         neg_ff <= opa_in[W-1] ^ opb_in[W-1];
         bz_ff  <= (opb_in == '0);
         rem_ff <= '0;
         dvd_ff <= mag(opa_in);
         quo_ff <= '0;
      end else if (busy_ff) begin
         prod_ff <= ma_ff * mb_part;
         if (cnt_ff == CNTW'(1)) begin
            acc_ff <= CW'(prod_ff);
         end else if (cnt_ff == CNTW'(2)) begin
            acc_ff <= acc_ff + (CW'(prod_ff) << HL);
         end
         if (op_ff == OP_DIV && cnt_ff != DIV_LAST) begin
            rem_ff <= ge ? diff[W-1:0] : r2[W-1:0];
            dvd_ff <= {dvd_ff[W-2:0], 1'b0};
            quo_ff <= {quo_ff[N-2:0], ge};
         end
      end
   end

   // filter state and working registers
   always_ff @(posedge clock) begin
      if (reset) begin
         x_ff   <= '0;
         v_ff   <= '0;
         pxx_ff <= W'(INIT_PXX);
         pxv_ff <= '0;
         pvv_ff <= W'(INIT_PVV);
      end else begin
         if (cmd.load) begin
            dt_ff  <= W'(time_step);
            dt2_ff <= W'({time_step, 1'b0});
            z_ff   <= sat64(64'(measurement));
         end
         if (done) begin
            case (d_ff)
               R_X:     x_ff    <= res_in;
               R_V:     v_ff    <= res_in;
               R_PXX:   pxx_ff  <= res_in;
               R_PXV:   pxv_ff  <= res_in;
               R_PVV:   pvv_ff  <= res_in;
               R_T0:    t0_ff   <= res_in;
               R_T1:    t1_ff   <= res_in;
               R_T2:    t2_ff   <= res_in;
               R_XP:    xp_ff   <= res_in;
               R_PXXP:  pxxp_ff <= res_in;
               R_PXVP:  pxvp_ff <= res_in;
               R_PVVP:  pvvp_ff <= res_in;
               R_Y:     y_ff    <= res_in;
               R_S:     s_ff    <= res_in;
               default: ;
            endcase
         end
      end
   end

   // output register
   assign x64 = 64'(x_ff);
   assign v64 = 64'(v_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         pos_ff <= x64[EST_W-1:0];
         vel_ff <= v64[EST_W-1:0];
      end
   end

   assign rsp_tvalid        = rsp_valid_ff;
   assign position_estimate = pos_ff;
   assign velocity_estimate = vel_ff;
   assign stat.done         = done;
   assign stat.out_free     = !rsp_valid_ff || rsp_tready;

`ifndef NO_ASSERTIONS
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.start |-> !busy_ff)
      else $error("operation started while unit busy");
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      cmd.start |=> busy_ff)
      else $error("unit did not go busy after start");
   a_done_frees: assert property (@(posedge clock) disable iff (reset)
      (done && !cmd.start) |=> !busy_ff)
      else $error("unit stayed busy after finishing");
`endif

endmodule

[hw/rtl/constant_velocity_kalman_1d.sv]
// ----------------------------------------------------------------------------
// constant_velocity_kalman_1d
// One-axis constant-velocity Kalman filter, signed fixed point.
// ----------------------------------------------------------------------------
//  channel  dir  handshake              content
//  req      in   req_tvalid/req_tready  time_step, measurement
//  rsp      out  rsp_tvalid/rsp_tready  position_estimate, velocity_estimate
//  csr      in   csr_wen                csr_index, csr_wdata
//
//  The radix-2 divider, run five times per item, takes most of an item's time.
//  Reset loads the filter state and register defaults.
//  A finished item waits in the output register; a new item is taken then.
// ----------------------------------------------------------------------------
module constant_velocity_kalman_1d #(
   parameter int FRAC_BITS = cvkf_pkg::FRAC_BITS_DEF,
   parameter int WORD_BITS = cvkf_pkg::WORD_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // [19:0] time_step, [51:20] measurement, [55:52] zero
   input  logic [cvkf_pkg::REQ_DATA_W-1:0]    req_tdata,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // [31:0] position_estimate, [63:32] velocity_estimate
   output logic [cvkf_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   input  logic                               csr_wen,
   input  logic [cvkf_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [cvkf_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import cvkf_pkg::*;

   cfg_type     cfg_ff;
   dp_cmd_type  cmd;
   dp_stat_type stat;
   logic signed [EST_W-1:0] pos, vel;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.process_noise     <= PROCESS_NOISE_RST;
         cfg_ff.measurement_noise <= MEASUREMENT_NOISE_RST;
         cfg_ff.periodic_mode     <= 1'b0;
      end else if (csr_wen) begin
         case (csr_index)
            CSR_PROCESS_NOISE:     cfg_ff.process_noise     <= csr_wdata[NOISE_W-1:0];
            CSR_MEASUREMENT_NOISE: cfg_ff.measurement_noise <= csr_wdata[NOISE_W-1:0];
            CSR_PERIODIC_MODE:     cfg_ff.periodic_mode     <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   cvkf_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .cmd        (cmd),
      .stat       (stat)
   );

   cvkf_dp #(
      .FRAC_BITS (FRAC_BITS),
      .WORD_BITS (WORD_BITS)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .stat              (stat),
      .cfg               (cfg_ff),
      .time_step         (req_tdata[TIME_STEP_W-1:0]),
      .measurement       (signed'(req_tdata[TIME_STEP_W+MEAS_W-1:TIME_STEP_W])),
      .rsp_tvalid        (rsp_tvalid),
      .rsp_tready        (rsp_tready),
      .position_estimate (pos),
      .velocity_estimate (vel)
   );

   assign rsp_tdata = {vel, pos};

endmodule
